// ===== rtl/tftp_rse_pkg.sv =====
// ----------------------------------------------------------------------------
// TFTP read sender engine package
// Shared types, codes and constants of the sender engine.
// ----------------------------------------------------------------------------
package tftp_rse_pkg;

   // Event queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Register file
   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic CSR_BLOCK_SIZE  = 1'b0;
   localparam logic CSR_RETRY_LIMIT = 1'b1;

   localparam logic [15:0] BLOCK_SIZE_RESET  = 16'd512;
   localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd5;

   // Protocol constants
   localparam logic [15:0] OP_ACK      = 16'd4;
   localparam logic [15:0] BLOCK_ANY   = 16'hffff;
   localparam logic [3:0]  STRAY_LIMIT = 4'd10;

   typedef enum logic [1:0] {
      KIND_START   = 2'd0,
      KIND_CHUNK   = 2'd1,
      KIND_PACKET  = 2'd2,
      KIND_TIMEOUT = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ACT_NONE   = 3'd0,
      ACT_FETCH  = 3'd1,
      ACT_SEND   = 3'd2,
      ACT_RESEND = 3'd3,
      ACT_NAK    = 3'd4,
      ACT_DONE   = 3'd5,
      ACT_ABORT  = 3'd6,
      ACT_GAVEUP = 3'd7
   } action_type;

   // Classified event, as handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic        with_options;
      logic        read_error;
      logic [15:0] length;        // chunk length, already clamped
      logic        is_ack;
      logic        block_any;
      logic [15:0] packet_block;
   } event_type;

   typedef struct packed {
      action_type  action;
      logic [15:0] block_number;
      logic [15:0] send_length;
   } result_type;

endpackage

// ===== rtl/tftp_rse_ifs.sv =====
// ----------------------------------------------------------------------------
// TFTP read sender engine channels
// Valid/ready channels for events in and actions out.
// ----------------------------------------------------------------------------
interface tftp_rse_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic        with_options;
   logic [15:0] chunk_length;
   logic        read_error;
   logic [15:0] packet_opcode;
   logic [15:0] packet_block;

   modport source (
      output valid, kind, with_options, chunk_length, read_error,
             packet_opcode, packet_block,
      input  ready
   );
   modport sink (
      input  valid, kind, with_options, chunk_length, read_error,
             packet_opcode, packet_block,
      output ready
   );
endinterface

interface tftp_rse_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [15:0] block_number;
   logic [15:0] send_length;

   modport source (
      output valid, action, block_number, send_length,
      input  ready
   );
   modport sink (
      input  valid, action, block_number, send_length,
      output ready
   );
endinterface

// ===== rtl/tftp_rse_front.sv =====
// ----------------------------------------------------------------------------
// TFTP read sender engine front
// Accept event beats, decode kind and opcode, clamp the chunk length.
// ----------------------------------------------------------------------------
module tftp_rse_front (
   tftp_rse_req_if.sink           req,
   input  logic [15:0]            block_size,
   input  logic                   queue_ready,
   output logic                   queue_push,
   output tftp_rse_pkg::event_type queue_event
);

   assign req.ready  = queue_ready;
   assign queue_push = req.valid & queue_ready;

   always_comb begin
      queue_event.kind         = tftp_rse_pkg::kind_type'(req.kind);
      queue_event.with_options = req.with_options;
      queue_event.read_error   = req.read_error;
      // clamp oversize chunks to the block size
      queue_event.length       = (req.chunk_length > block_size) ? block_size
                                                                 : req.chunk_length;
      queue_event.is_ack       = (req.packet_opcode == tftp_rse_pkg::OP_ACK);
      queue_event.block_any    = (req.packet_block == tftp_rse_pkg::BLOCK_ANY);
      queue_event.packet_block = req.packet_block;
   end

endmodule

// ===== rtl/tftp_rse_queue.sv =====
// ----------------------------------------------------------------------------
// TFTP read sender engine queue
// Short FIFO of classified events between front and back.
// ----------------------------------------------------------------------------
module tftp_rse_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  tftp_rse_pkg::event_type push_event,
   output logic                    ready,
   input  logic                    pop,
   output logic                    valid,
   output tftp_rse_pkg::event_type head_event
);

   localparam int unsigned QD = tftp_rse_pkg::QUEUE_DEPTH;
   localparam int unsigned IW = tftp_rse_pkg::QIDX_W;
   localparam int unsigned CW = tftp_rse_pkg::QCNT_W;

   tftp_rse_pkg::event_type entry_ff [QD];
   logic [IW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [IW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   logic do_push, do_pop;

   assign ready      = (count_ff != CW'(QD));
   assign valid      = (count_ff != '0);
   assign head_event = entry_ff[rd_ptr_ff];
   assign do_push    = push & ready;
   assign do_pop     = pop & valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IW'(QD - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IW'(QD - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_event;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QD))
      else $error("queue count above depth");

endmodule

// ===== rtl/tftp_rse_back.sv =====
// ----------------------------------------------------------------------------
// TFTP read sender engine back
// Run the transfer state machine on each event and register one action.
// ----------------------------------------------------------------------------
module tftp_rse_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [15:0]             block_size,
   input  logic [7:0]              retry_limit,
   input  logic                    queue_valid,
   input  tftp_rse_pkg::event_type queue_event,
   output logic                    queue_pop,
   tftp_rse_rsp_if.source          rsp
);

   typedef enum logic [3:0] {
      PH_IDLE  = 4'b0001,
      PH_OACK  = 4'b0010,
      PH_CHUNK = 4'b0100,
      PH_DATA  = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      J_ACCEPT = 2'd0,
      J_RESEND = 2'd1,
      J_ERROR  = 2'd2,
      J_IGNORE = 2'd3
   } judge_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] cur_block_ff, cur_block_in;
   logic [15:0] last_len_ff, last_len_in;
   logic [7:0]  resend_cnt_ff, resend_cnt_in;
   logic [3:0]  stray_cnt_ff, stray_cnt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   tftp_rse_pkg::result_type rsp_data_ff, rsp_data_in;

   logic        advance;
   logic [15:0] next_block;
   logic [3:0]  stray_inc;
   logic        ack_hit;
   judge_type   judge;

   assign advance    = queue_valid & (~rsp_valid_ff | rsp.ready);
   assign queue_pop  = advance;
   assign next_block = cur_block_ff + 16'd1;
   assign stray_inc  = stray_cnt_ff + 4'd1;
   assign ack_hit    = (queue_event.packet_block == cur_block_ff) ||
                       (queue_event.packet_block == next_block);

   always_comb begin
      if (queue_event.kind == tftp_rse_pkg::KIND_TIMEOUT) begin
         judge = J_RESEND;
      end else if (!queue_event.is_ack) begin
         judge = J_ERROR;
      end else if (ack_hit) begin
         judge = J_ACCEPT;
      end else if (queue_event.block_any) begin
         judge = J_RESEND;
      end else if (stray_inc >= tftp_rse_pkg::STRAY_LIMIT) begin
         judge = J_RESEND;
      end else begin
         judge = J_IGNORE;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      cur_block_in  = cur_block_ff;
      last_len_in   = last_len_ff;
      resend_cnt_in = resend_cnt_ff;
      stray_cnt_in  = stray_cnt_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp.ready;
      rsp_data_in   = rsp_data_ff;

      if (advance) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.action       = tftp_rse_pkg::ACT_NONE;
         rsp_data_in.block_number = '0;
         rsp_data_in.send_length  = '0;
         case (queue_event.kind)
            tftp_rse_pkg::KIND_START: begin
               last_len_in   = '0;
               resend_cnt_in = '0;
               stray_cnt_in  = '0;
               if (queue_event.with_options) begin
                  cur_block_in = '0;
                  phase_in     = PH_OACK;
               end else begin
                  cur_block_in             = 16'd1;
                  phase_in                 = PH_CHUNK;
                  rsp_data_in.action       = tftp_rse_pkg::ACT_FETCH;
                  rsp_data_in.block_number = 16'd1;
               end
            end
            tftp_rse_pkg::KIND_CHUNK: begin
               if (phase_ff == PH_CHUNK) begin
                  if (queue_event.read_error) begin
                     rsp_data_in.action = tftp_rse_pkg::ACT_NAK;
                     phase_in           = PH_IDLE;
                  end else begin
                     last_len_in              = queue_event.length;
                     resend_cnt_in            = '0;
                     stray_cnt_in             = '0;
                     phase_in                 = PH_DATA;
                     rsp_data_in.action       = tftp_rse_pkg::ACT_SEND;
                     rsp_data_in.block_number = cur_block_ff;
                     rsp_data_in.send_length  = queue_event.length;
                  end
               end
            end
            tftp_rse_pkg::KIND_PACKET, tftp_rse_pkg::KIND_TIMEOUT: begin
               if (phase_ff == PH_OACK || phase_ff == PH_DATA) begin
                  // a stray ack bumps the count, unless the resend it forces clears it again
                  if (queue_event.kind == tftp_rse_pkg::KIND_PACKET && queue_event.is_ack
                      && !ack_hit && !queue_event.block_any) begin
                     stray_cnt_in = stray_inc;
                  end
                  case (judge)
                     J_ERROR: begin
                        rsp_data_in.action = tftp_rse_pkg::ACT_ABORT;
                        phase_in           = PH_IDLE;
                     end
                     J_ACCEPT: begin
                        if (phase_ff == PH_DATA && last_len_ff != block_size) begin
                           rsp_data_in.action = tftp_rse_pkg::ACT_DONE;
                           phase_in           = PH_IDLE;
                        end else begin
                           cur_block_in             = next_block;
                           stray_cnt_in             = '0;
                           phase_in                 = PH_CHUNK;
                           rsp_data_in.action       = tftp_rse_pkg::ACT_FETCH;
                           rsp_data_in.block_number = next_block;
                        end
                     end
                     J_RESEND: begin
                        if (phase_ff == PH_DATA && resend_cnt_ff < retry_limit) begin
                           resend_cnt_in            = resend_cnt_ff + 8'd1;
                           stray_cnt_in             = '0;
                           rsp_data_in.action       = tftp_rse_pkg::ACT_RESEND;
                           rsp_data_in.block_number = cur_block_ff;
                           rsp_data_in.send_length  = last_len_ff;
                        end else begin
                           rsp_data_in.action = tftp_rse_pkg::ACT_GAVEUP;
                           phase_in           = PH_IDLE;
                        end
                     end
                     default: begin
                        rsp_data_in.action = tftp_rse_pkg::ACT_NONE;
                     end
                  endcase
               end
            end
            default: begin
               rsp_data_in.action = tftp_rse_pkg::ACT_NONE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         cur_block_ff  <= '0;
         last_len_ff   <= '0;
         resend_cnt_ff <= '0;
         stray_cnt_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         cur_block_ff  <= cur_block_in;
         last_len_ff   <= last_len_in;
         resend_cnt_ff <= resend_cnt_in;
         stray_cnt_ff  <= stray_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.action       = rsp_data_ff.action;
   assign rsp.block_number = rsp_data_ff.block_number;
   assign rsp.send_length  = rsp_data_ff.send_length;

   a_fetch_waits_chunk: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_data_in.action == tftp_rse_pkg::ACT_FETCH |=> phase_ff == PH_CHUNK)
      else $error("fetch issued without entering chunk wait");

   a_final_goes_idle: assert property (@(posedge clock) disable iff (reset)
      advance && (rsp_data_in.action == tftp_rse_pkg::ACT_DONE ||
                  rsp_data_in.action == tftp_rse_pkg::ACT_ABORT ||
                  rsp_data_in.action == tftp_rse_pkg::ACT_NAK ||
                  rsp_data_in.action == tftp_rse_pkg::ACT_GAVEUP)
      |=> phase_ff == PH_IDLE)
      else $error("terminal action left the transfer running");

   a_send_enters_data: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_data_in.action == tftp_rse_pkg::ACT_SEND
      |=> phase_ff == PH_DATA && last_len_ff == $past(queue_event.length))
      else $error("send did not latch the chunk length");

   a_send_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.action == tftp_rse_pkg::ACT_SEND
      |-> rsp_data_ff.send_length <= block_size)
      else $error("send length above block size");

endmodule

// ===== rtl/tftp_read_sender_engine.sv =====
// ----------------------------------------------------------------------------
// TFTP read sender engine
// Lockstep DATA/ACK sender of a TFTP read transfer: one action per event.
// ----------------------------------------------------------------------------
//  channel  dir  handshake           beat contents
//  req      in   valid/ready         kind, with_options, chunk_length,
//                                    read_error, packet_opcode, packet_block
//  rsp      out  valid/ready         action, block_number, send_length
//  csr      in   APB psel/penable    block_size (0x0), retry_limit (0x4)
//
//  One event beat per cycle sustained while rsp is not stalled; an event's
//  action passes the queue write, then the state update into the rsp register.
//  The front decodes and clamps into a two-entry queue; the back updates the
//  transfer state and fills the rsp register, so either side stalls alone.
//  Synchronous reset: phase idle, counters zero, block_size 512, retry 5.
//  req.ready drops only when the queue is full behind a stalled rsp.
// ----------------------------------------------------------------------------
module tftp_read_sender_engine (
   input  logic                                 clock,
   input  logic                                 reset,
   tftp_rse_req_if.sink                         req,
   tftp_rse_rsp_if.source                       rsp,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [tftp_rse_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                          pwdata,
   output logic [31:0]                          prdata,
   output logic                                 pready
);

   // Configuration registers
   logic [15:0] block_size_ff;
   logic [7:0]  retry_limit_ff;
   logic        csr_write;
   logic        csr_index;

   // Front to queue, queue to back
   logic                    queue_ready;
   logic                    queue_push;
   tftp_rse_pkg::event_type front_event;
   logic                    queue_valid;
   logic                    queue_pop;
   tftp_rse_pkg::event_type head_event;

   // APB: zero-wait, write lands at the access phase
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;
   assign csr_index = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         block_size_ff  <= tftp_rse_pkg::BLOCK_SIZE_RESET;
         retry_limit_ff <= tftp_rse_pkg::RETRY_LIMIT_RESET;
      end else if (csr_write) begin
         if (csr_index == tftp_rse_pkg::CSR_BLOCK_SIZE) begin
            block_size_ff <= pwdata[15:0];
         end else begin
            retry_limit_ff <= pwdata[7:0];
         end
      end
   end

   // Read back the addressed register, zero-extended
   always_comb begin
      if (csr_index == tftp_rse_pkg::CSR_BLOCK_SIZE) begin
         prdata = {16'd0, block_size_ff};
      end else begin
         prdata = {24'd0, retry_limit_ff};
      end
   end

   // Decode and clamp incoming event beats
   tftp_rse_front u_front (
      .req         (req),
      .block_size  (block_size_ff),
      .queue_ready (queue_ready),
      .queue_push  (queue_push),
      .queue_event (front_event)
   );

   // Decouple front from back
   tftp_rse_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_event (front_event),
      .ready      (queue_ready),
      .pop        (queue_pop),
      .valid      (queue_valid),
      .head_event (head_event)
   );

   // Advance the transfer and hold the action until rsp takes it
   tftp_rse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .block_size  (block_size_ff),
      .retry_limit (retry_limit_ff),
      .queue_valid (queue_valid),
      .queue_event (head_event),
      .queue_pop   (queue_pop),
      .rsp         (rsp)
   );

endmodule
